/* hw/rtl/swks_pkg.sv */
// Shared types, constants and control structs for the sliding-window rank filter.
package swks_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 64;
   localparam int VALUE_W = 32;
   localparam int K_W = 7;
   localparam int STATUS_W = 2;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_DROP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [K_W-1:0] K_RANK_RESET = 7'd1;

   typedef struct packed {
      logic req_type;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] kth_value;
      logic kth_valid;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic ins;
      logic fetch;
      logic srch;
      logic shift;
      logic rank;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic append_ok;
      logic drop_ok;
      logic ins_move;
      logic match;
      logic pos_last;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/swks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/swks_ctrl.sv */
// Controller state machine that sequences each item through the datapath.
module swks_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  swks_pkg::sts_type sts,
   output swks_pkg::cmd_type cmd
);
   import swks_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_INS     = 7'b0000010,
      ST_FETCH   = 7'b0000100,
      ST_SRCH    = 7'b0001000,
      ST_SHIFT   = 7'b0010000,
      ST_RANK_RD = 7'b0100000,
      ST_RANK    = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (sts.append_ok) begin
                  state_in = ST_INS;
               end else if (sts.drop_ok) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RANK_RD;
               end
            end
         end
         ST_INS: begin
            cmd.ins = 1'b1;
            if (!sts.ins_move) begin
               state_in = ST_RANK_RD;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_SRCH;
         end
         ST_SRCH: begin
            cmd.srch = 1'b1;
            if (sts.match) begin
               state_in = ST_SHIFT;
            end else if (sts.pos_last) begin
               state_in = ST_RANK_RD;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.pos_last) begin
               state_in = ST_RANK_RD;
            end
         end
         ST_RANK_RD: begin
            cmd.rank = 1'b1;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            cmd.rank = 1'b1;
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/swks_datapath.sv */
// Datapath: arrival and sorted stores, window pointers, rank register and result register.
module swks_datapath #(
   parameter int WINDOW_DEPTH = swks_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swks_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output swks_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [swks_pkg::K_W-1:0]  csr_wr_data,
   input  swks_pkg::cmd_type         cmd,
   output swks_pkg::sts_type         sts
);
   import swks_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int XW = CW + 1;
   localparam int CMPW = (CW > K_W) ? CW : K_W;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [K_W-1:0] k_rank_ff, k_rank_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] x_ff, x_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [XW-1:0] pos_ext, count_ext, tail_sum, tail_wrap, sorted_raddr_x;
   logic [AW-1:0] tail_addr;
   logic [CMPW-1:0] k_minus_one;
   logic full, empty, k_valid, drop_done;

   logic arr_wr_en;
   logic [VALUE_W-1:0] arr_rd_data;
   logic srt_wr_en;
   logic [AW-1:0] srt_wr_addr;
   logic [VALUE_W-1:0] srt_wr_data, srt_rd_data;

   assign pos_ext = {1'b0, pos_ff};
   assign count_ext = {1'b0, count_ff};
   assign full = (count_ff == CW'(WINDOW_DEPTH));
   assign empty = (count_ff == '0);

   assign tail_sum = XW'(oldest_ff) + count_ext;
   assign tail_wrap = (tail_sum >= XW'(WINDOW_DEPTH)) ? tail_sum - XW'(WINDOW_DEPTH) : tail_sum;
   assign tail_addr = tail_wrap[AW-1:0];

   assign k_minus_one = CMPW'(k_rank_ff) - CMPW'(1);
   assign k_valid = (k_rank_ff != '0) && (CMPW'(k_rank_ff) <= CMPW'(count_ff));

   assign sts.append_ok = (req_payload.req_type == REQ_APPEND) && !full;
   assign sts.drop_ok = (req_payload.req_type == REQ_DROP) && !empty;
   assign sts.ins_move = (pos_ff != '0) && ($signed(value_ff) < $signed(srt_rd_data));
   assign sts.match = (srt_rd_data == x_ff);
   assign sts.pos_last = ((pos_ext + XW'(1)) >= count_ext);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign drop_done = (cmd.srch && !sts.match && sts.pos_last) || (cmd.shift && sts.pos_last);
   assign arr_wr_en = cmd.start && sts.append_ok;

   always_comb begin
      sorted_raddr_x = '0;
      if (cmd.start) begin
         sorted_raddr_x = count_ext - XW'(1);
      end else if (cmd.ins) begin
         sorted_raddr_x = pos_ext - XW'(2);
      end else if (cmd.srch) begin
         sorted_raddr_x = pos_ext + XW'(1);
      end else if (cmd.shift) begin
         sorted_raddr_x = pos_ext + XW'(2);
      end else if (cmd.rank) begin
         sorted_raddr_x = XW'(k_minus_one[AW-1:0]);
      end
   end

   always_comb begin
      srt_wr_en = 1'b0;
      srt_wr_addr = pos_ff[AW-1:0];
      srt_wr_data = srt_rd_data;
      if (cmd.ins) begin
         srt_wr_en = 1'b1;
         srt_wr_data = sts.ins_move ? srt_rd_data : value_ff;
      end else if (cmd.shift && !sts.pos_last) begin
         srt_wr_en = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      oldest_in = oldest_ff;
      pos_in = pos_ff;
      k_rank_in = k_rank_ff;
      value_in = value_ff;
      x_in = x_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (csr_wr_en) begin
         k_rank_in = csr_wr_data;
      end
      if (cmd.start) begin
         value_in = req_payload.value;
         pos_in = count_ff;
         if (req_payload.req_type == REQ_APPEND) begin
            status_in = full ? STATUS_FULL : STATUS_OK;
         end else begin
            status_in = empty ? STATUS_EMPTY : STATUS_OK;
         end
      end
      if (cmd.ins) begin
         if (sts.ins_move) begin
            pos_in = pos_ff - CW'(1);
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.fetch) begin
         x_in = arr_rd_data;
         pos_in = '0;
      end
      if ((cmd.srch && !sts.match) || (cmd.shift && !sts.pos_last)) begin
         pos_in = pos_ff + CW'(1);
      end
      if (drop_done) begin
         count_in = count_ff - CW'(1);
         oldest_in = (oldest_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.kth_value = k_valid ? srt_rd_data : '0;
         rsp_payload_in.kth_valid = k_valid;
         rsp_payload_in.status = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         oldest_ff <= '0;
         k_rank_ff <= K_RANK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         oldest_ff <= oldest_in;
         k_rank_ff <= k_rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      value_ff <= value_in;
      x_ff <= x_in;
      status_ff <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   swks_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_arrival_ram (
      .clock   (clock),
      .wr_en   (arr_wr_en),
      .wr_addr (tail_addr),
      .wr_data (req_payload.value),
      .rd_addr (oldest_ff),
      .rd_data (arr_rd_data)
   );

   swks_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_sorted_ram (
      .clock   (clock),
      .wr_en   (srt_wr_en),
      .wr_addr (srt_wr_addr),
      .wr_data (srt_wr_data),
      .rd_addr (sorted_raddr_x[AW-1:0]),
      .rd_data (srt_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hw/rtl/sliding_window_kth_smallest_core.sv */
// Top level of the sliding-window k-th smallest rank filter.
// Each request transfer either appends a signed value to the right end of a FIFO
// window or drops the oldest value. Every request produces exactly one response
// transfer carrying the k-th smallest window value, a valid flag and a status code.
// The user must write the rank k through the csr port only while the block is
// idle; the block does not enforce this. Reset sets the rank to 1. A sorted copy
// of the window lives in a RAM with one read port, and insert and removal step
// through it one entry per cycle. An append moves the larger entries up one by
// one before it writes the new value; a drop first searches for the oldest value,
// then closes the gap. A rejected append or drop goes straight to the rank read.
// The next request is taken the cycle after the response is loaded, so one item
// is in work at a time.
// The response sits in an output register: while the receiver stalls, the block
// still accepts and processes the next request, and then waits with its result.
// Reset empties the window and clears the response valid flag; no clearing
// pass is needed.
module sliding_window_kth_smallest_core #(
   parameter int WINDOW_DEPTH = swks_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  swks_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output swks_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [swks_pkg::K_W-1:0]  csr_wr_data
);
   import swks_pkg::*;

   cmd_type cmd;
   sts_type sts;

   swks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   swks_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   a_one_item_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an item was still in work");

   a_invalid_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.kth_valid) |-> (rsp_payload.kth_value == '0))
      else $error("response value not zero without a valid rank");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK || rsp_payload.status == STATUS_FULL
                     || rsp_payload.status == STATUS_EMPTY))
      else $error("response status code out of range");

   a_load_after_rank: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.rank))
      else $error("response loaded without a rank read");

endmodule
